// ===== rtl/core/yuv2rgb_pkg.sv =====
package yuv2rgb_pkg;

   // Fraction bits of the chroma gain registers.
   localparam int COEF_FRAC_BITS = 16;

   localparam int PIX_W   = 8;
   localparam int COEF_W  = 18;
   localparam int FMT_W   = 2;
   localparam int CSR_DATA_W = 32;
   localparam int NUM_REGS   = 5;
   localparam int CSR_ADDR_W = $clog2(4 * NUM_REGS);
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   // Gain times centered chroma: 19-bit signed gain by 8-bit signed chroma.
   localparam int PROD_W = COEF_W + 1 + PIX_W;
   localparam int BASE_W = PIX_W + COEF_FRAC_BITS;
   localparam int ACC_W  = ((BASE_W > (PROD_W - 1)) ? BASE_W : (PROD_W - 1)) + 2;
   localparam int QUOT_W = ACC_W - COEF_FRAC_BITS;

   // Pixel formats.
   localparam logic [FMT_W-1:0] FMT_YUYV = 2'd0;
   localparam logic [FMT_W-1:0] FMT_NV12 = 2'd1;
   localparam logic [FMT_W-1:0] FMT_NV21 = 2'd2;

   // Register indexes.
   localparam logic [REG_IDX_W-1:0] REG_PIXEL_FORMAT    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COEF_V_TO_RED   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_COEF_U_TO_GREEN = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COEF_V_TO_GREEN = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COEF_U_TO_BLUE  = 3'd4;

   // Reset gains: 1.4075, 0.3455, 0.7169 and 1.779 in Q16.
   localparam logic [COEF_W-1:0] RST_COEF_V_TO_RED   = 18'd92242;
   localparam logic [COEF_W-1:0] RST_COEF_U_TO_GREEN = 18'd22643;
   localparam logic [COEF_W-1:0] RST_COEF_V_TO_GREEN = 18'd46983;
   localparam logic [COEF_W-1:0] RST_COEF_U_TO_BLUE  = 18'd116589;

   localparam logic [PIX_W-1:0] CHROMA_OFFSET = 8'd128;
   localparam logic [PIX_W-1:0] CHANNEL_MAX   = 8'd255;

   // One pixel on its way into the multipliers; chroma is already centered.
   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic [PIX_W-1:0] u;
      logic [PIX_W-1:0] v;
      logic             last;
   } pixel_type;

endpackage

// ===== rtl/core/yuv_to_rgb_converter_core.sv =====
// An accepted item is registered in turn in stage 1, the chroma products, the channel
// accumulators and the clamped result. NV12 and NV21 items never raise busy; a YUYV item's
// two pixels share the single result port and busy stays high for the second one.
// The result port cannot be stalled; every result is shown for exactly one cycle.
// Reset is synchronous: it empties the pipeline, clears busy and loads the default
// format (YUYV) and the default BT.601 gains.
module yuv_to_rgb_converter_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [yuv2rgb_pkg::PIX_W-1:0]         req_luma_a,
   input  logic [yuv2rgb_pkg::PIX_W-1:0]         req_chroma_first,
   input  logic [yuv2rgb_pkg::PIX_W-1:0]         req_luma_b,
   input  logic [yuv2rgb_pkg::PIX_W-1:0]         req_chroma_second,
   output logic                                  rsp_valid,
   output logic [yuv2rgb_pkg::PIX_W-1:0]         rsp_red,
   output logic [yuv2rgb_pkg::PIX_W-1:0]         rsp_green,
   output logic [yuv2rgb_pkg::PIX_W-1:0]         rsp_blue,
   output logic                                  rsp_last_pixel,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [yuv2rgb_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [yuv2rgb_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [yuv2rgb_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                  pready
);
   import yuv2rgb_pkg::*;

   // Configuration registers.
   logic [FMT_W-1:0]  fmt_ff;
   logic [COEF_W-1:0] coef_vr_ff;
   logic [COEF_W-1:0] coef_ug_ff;
   logic [COEF_W-1:0] coef_vg_ff;
   logic [COEF_W-1:0] coef_ub_ff;

   logic                 csr_write;
   logic [REG_IDX_W-1:0] csr_index;

   // Issue stage: the second YUYV pixel waits here while the first one moves into stage 1.
   logic      accept;
   logic      pend_valid_ff, pend_valid_in;
   pixel_type pend_ff, pend_in;

   // Stage 1: selected and centered pixel.
   logic      s1_valid_ff, s1_valid_in;
   pixel_type s1_ff, s1_in;

   // Stage 2: chroma products.
   logic                     s2_valid_ff;
   logic [PIX_W-1:0]         s2_luma_ff;
   logic                     s2_last_ff;
   logic signed [PROD_W-1:0] prod_vr_ff, prod_vr_in;
   logic signed [PROD_W-1:0] prod_ug_ff, prod_ug_in;
   logic signed [PROD_W-1:0] prod_vg_ff, prod_vg_in;
   logic signed [PROD_W-1:0] prod_ub_ff, prod_ub_in;

   // Stage 3: channel accumulators.
   logic                    s3_valid_ff;
   logic                    s3_last_ff;
   logic signed [ACC_W-1:0] acc_r_ff, acc_r_in;
   logic signed [ACC_W-1:0] acc_g_ff, acc_g_in;
   logic signed [ACC_W-1:0] acc_b_ff, acc_b_in;
   logic signed [ACC_W-1:0] base;

   // Stage 4: clamped result.
   logic             out_valid_ff;
   logic [PIX_W-1:0] out_red_ff, out_red_in;
   logic [PIX_W-1:0] out_green_ff, out_green_in;
   logic [PIX_W-1:0] out_blue_ff, out_blue_in;
   logic             out_last_ff;

   function automatic logic [PIX_W-1:0] clamp_channel(input logic signed [ACC_W-1:0] acc);
      logic [QUOT_W-1:0] quot;
      quot = acc[ACC_W-1:COEF_FRAC_BITS];
      if (acc[ACC_W-1]) begin
         return '0;
      end else if (quot > QUOT_W'(CHANNEL_MAX)) begin
         return CHANNEL_MAX;
      end else begin
         return quot[PIX_W-1:0];
      end
   endfunction

   // ---------------------------------------------------------------- CSR port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      case (csr_index)
         REG_PIXEL_FORMAT:    prdata = CSR_DATA_W'(fmt_ff);
         REG_COEF_V_TO_RED:   prdata = CSR_DATA_W'(coef_vr_ff);
         REG_COEF_U_TO_GREEN: prdata = CSR_DATA_W'(coef_ug_ff);
         REG_COEF_V_TO_GREEN: prdata = CSR_DATA_W'(coef_vg_ff);
         REG_COEF_U_TO_BLUE:  prdata = CSR_DATA_W'(coef_ub_ff);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff     <= FMT_YUYV;
         coef_vr_ff <= RST_COEF_V_TO_RED;
         coef_ug_ff <= RST_COEF_U_TO_GREEN;
         coef_vg_ff <= RST_COEF_V_TO_GREEN;
         coef_ub_ff <= RST_COEF_U_TO_BLUE;
      end else if (csr_write) begin
         case (csr_index)
            REG_PIXEL_FORMAT:    fmt_ff     <= pwdata[FMT_W-1:0];
            REG_COEF_V_TO_RED:   coef_vr_ff <= pwdata[COEF_W-1:0];
            REG_COEF_U_TO_GREEN: coef_ug_ff <= pwdata[COEF_W-1:0];
            REG_COEF_V_TO_GREEN: coef_vg_ff <= pwdata[COEF_W-1:0];
            REG_COEF_U_TO_BLUE:  coef_ub_ff <= pwdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ issue stage
   assign busy   = pend_valid_ff;
   assign accept = start && !busy;

   always_comb begin
      pend_valid_in = 1'b0;
      pend_in       = pend_ff;
      s1_valid_in   = 1'b0;
      s1_in         = s1_ff;
      if (pend_valid_ff) begin
         s1_valid_in = 1'b1;
         s1_in       = pend_ff;
      end else if (accept) begin
         s1_valid_in = 1'b1;
         s1_in.luma  = req_luma_a;
         // Flipping the top bit subtracts 128 and leaves a signed byte.
         case (fmt_ff)
            FMT_YUYV: begin
               s1_in.u         = req_chroma_first ^ CHROMA_OFFSET;
               s1_in.v         = req_chroma_second ^ CHROMA_OFFSET;
               s1_in.last      = 1'b0;
               pend_valid_in   = 1'b1;
               pend_in.luma    = req_luma_b;
               pend_in.u       = req_chroma_first ^ CHROMA_OFFSET;
               pend_in.v       = req_chroma_second ^ CHROMA_OFFSET;
               pend_in.last    = 1'b1;
            end
            FMT_NV21: begin
               s1_in.u    = req_chroma_second ^ CHROMA_OFFSET;
               s1_in.v    = req_chroma_first ^ CHROMA_OFFSET;
               s1_in.last = 1'b1;
            end
            FMT_NV12: begin
               s1_in.u    = req_chroma_first ^ CHROMA_OFFSET;
               s1_in.v    = req_chroma_second ^ CHROMA_OFFSET;
               s1_in.last = 1'b1;
            end
            default: begin
               // The unused code reads the chroma pair as NV12 does.
               s1_in.u    = req_chroma_first ^ CHROMA_OFFSET;
               s1_in.v    = req_chroma_second ^ CHROMA_OFFSET;
               s1_in.last = 1'b1;
            end
         endcase
      end
   end

   // -------------------------------------------------------- datapath stages
   always_comb begin
      prod_vr_in = $signed({1'b0, coef_vr_ff}) * $signed(s1_ff.v);
      prod_ug_in = $signed({1'b0, coef_ug_ff}) * $signed(s1_ff.u);
      prod_vg_in = $signed({1'b0, coef_vg_ff}) * $signed(s1_ff.v);
      prod_ub_in = $signed({1'b0, coef_ub_ff}) * $signed(s1_ff.u);
   end

   always_comb begin
      base     = $signed({{(ACC_W - BASE_W){1'b0}}, s2_luma_ff, {COEF_FRAC_BITS{1'b0}}});
      acc_r_in = base + {{(ACC_W - PROD_W){prod_vr_ff[PROD_W-1]}}, prod_vr_ff};
      acc_g_in = base - {{(ACC_W - PROD_W){prod_ug_ff[PROD_W-1]}}, prod_ug_ff}
                      - {{(ACC_W - PROD_W){prod_vg_ff[PROD_W-1]}}, prod_vg_ff};
      acc_b_in = base + {{(ACC_W - PROD_W){prod_ub_ff[PROD_W-1]}}, prod_ub_ff};
   end

   always_comb begin
      out_red_in   = clamp_channel(acc_r_ff);
      out_green_in = clamp_channel(acc_g_ff);
      out_blue_in  = clamp_channel(acc_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         out_valid_ff  <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff      <= pend_in;
      s1_ff        <= s1_in;
      s2_luma_ff   <= s1_ff.luma;
      s2_last_ff   <= s1_ff.last;
      prod_vr_ff   <= prod_vr_in;
      prod_ug_ff   <= prod_ug_in;
      prod_vg_ff   <= prod_vg_in;
      prod_ub_ff   <= prod_ub_in;
      s3_last_ff   <= s2_last_ff;
      acc_r_ff     <= acc_r_in;
      acc_g_ff     <= acc_g_in;
      acc_b_ff     <= acc_b_in;
      out_last_ff  <= s3_last_ff;
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_red        = out_red_ff;
   assign rsp_green      = out_green_ff;
   assign rsp_blue       = out_blue_ff;
   assign rsp_last_pixel = out_last_ff;

`ifndef SYNTH
   // Busy is only ever raised by a YUYV transfer in the cycle before.
   a_busy_from_yuyv: assert property (@(posedge clock) disable iff (reset)
      busy |-> $past(accept && (fmt_ff == FMT_YUYV)))
      else $error("busy without a preceding YUYV transfer");

   // Every accepted item must show its first pixel on the result port.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("result missing four cycles after a transfer");

   // The first pixel of a YUYV pair is followed at once by the final one.
   a_pair_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_pixel) |=> (rsp_valid && rsp_last_pixel))
      else $error("YUYV pair broken at the result port");
`endif

endmodule
